// ===== sv/htw_pkg.sv =====
package htw_pkg;

  localparam int NODE_DEPTH_DEF = 512;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 8;
  localparam int CNT_W  = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // one node store entry, 28 bits
  typedef struct packed {
    logic [SYM_W-1:0] leaf_symbol;
    logic             has_right;
    logic             has_left;
    logic [IDX_W-1:0] right_index;
    logic [IDX_W-1:0] left_index;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic              has_left;
    logic              has_right;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [CODE_W-1:0] code_byte;
    logic [CNT_W-1:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_item;
  } out_item_t;

  // code bit shifter control and status
  typedef struct packed {
    logic load;
    logic shift;
  } bs_ctl_t;

  typedef struct packed {
    logic msb;
    logic one_left;
    logic empty;
  } bs_stat_t;

endpackage

// ===== sv/htw_ram.sv =====
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/htw_bitser.sv =====
module htw_bitser
  import htw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bs_ctl_t           ctl,
  input  logic [CODE_W-1:0] code_byte,
  input  logic [CNT_W-1:0]  bit_count,
  output bs_stat_t          stat
);

  logic [CODE_W-1:0] shreg;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_sat;

  // counts above a full byte saturate
  assign cnt_sat = (bit_count > CNT_W'(CODE_W)) ? CNT_W'(CODE_W) : bit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      // first valid bit lands in the MSB
      shreg <= code_byte << (CNT_W'(CODE_W) - cnt_sat);
      cnt   <= cnt_sat;
    end else if (ctl.shift) begin
      shreg <= {shreg[CODE_W-2:0], 1'b0};
      cnt   <= cnt - CNT_W'(1);
    end
  end

  assign stat.msb      = shreg[CODE_W-1];
  assign stat.one_left = (cnt == CNT_W'(1));
  assign stat.empty    = (cnt == '0);

endmodule

// ===== sv/huffman_tree_walk_decoder.sv =====
// Channel | Dir | Handshake               | Payload
// in      | in  | in_valid / in_stall     | in_data   (in_item_t: load node or decode byte)
// out     | out | out_valid / out_stall   | out_data  (out_item_t: symbol, last_of_item)
// cfg     | in  | cfg_valid / cfg_ready   | cfg_data  (root_index, 9 bits)
//
// Load: the node is written to the store when the item is accepted. Decode: a bit
// whose child is absent is dropped; a bit that follows a child reads that child; a node
// fetch comes at the start (skipped while the parked node is still on the store output)
// and after each symbol but the last, all through the single registered read port.
// rst is synchronous; the node store is not cleared and reads undefined until loaded.
// A stalled output holds the walk when a second symbol is ready and the final flush.
module huffman_tree_walk_decoder
  import htw_pkg::*;
#(
  parameter int NODE_DEPTH = NODE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_data
);

  localparam int AW = $clog2(NODE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_CHILD = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] root_index;
  logic [IDX_W-1:0] current_node, current_node_next;
  logic             mid_code, mid_code_next;
  logic             data_ok, data_ok_next;  // RAM output holds the current node
  logic [IDX_W-1:0] child_idx, child_idx_next;
  logic             pend_valid, pend_valid_next;
  logic [SYM_W-1:0] pend_sym, pend_sym_next;
  logic             rd_zero;

  // node store ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] rd_idx;
  logic [NODE_W-1:0] ram_rdata;
  node_t            node_rd, node_wr;

  // code bit shifter
  bs_ctl_t  bs_ctl;
  bs_stat_t bs_stat;

  // output register
  logic      out_free;
  logic      push;
  out_item_t push_data;

  logic          accept;
  logic [IDX_W-1:0] walk_cur;
  logic          step_has;
  logic [IDX_W-1:0] step_child;
  logic          child_leaf;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  // node fields of a load transaction
  assign node_wr.leaf_symbol = in_data.leaf_symbol;
  assign node_wr.has_right   = in_data.has_right;
  assign node_wr.has_left    = in_data.has_left;
  assign node_wr.right_index = in_data.right_index;
  assign node_wr.left_index  = in_data.left_index;

  assign ram_we = accept && (in_data.opcode == OP_LOAD) &&
                  (32'(in_data.node_index) < 32'(NODE_DEPTH));

  htw_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_data.node_index)),
    .wdata(node_wr),
    .re   (ram_re),
    .raddr(AW'(rd_idx)),
    .rdata(ram_rdata)
  );

  // indices beyond the store read as an empty leaf
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_zero <= !(32'(rd_idx) < 32'(NODE_DEPTH));
    end
  end

  assign node_rd = rd_zero ? '0 : node_t'(ram_rdata);

  htw_bitser u_bits (
    .clk      (clk),
    .rst      (rst),
    .ctl      (bs_ctl),
    .code_byte(in_data.code_byte),
    .bit_count(in_data.bit_count),
    .stat     (bs_stat)
  );

  assign walk_cur   = mid_code ? current_node : root_index;
  assign step_has   = bs_stat.msb ? node_rd.has_right : node_rd.has_left;
  assign step_child = bs_stat.msb ? node_rd.right_index : node_rd.left_index;
  assign child_leaf = !node_rd.has_left && !node_rd.has_right;

  always_comb begin
    state_next        = state;
    current_node_next = current_node;
    mid_code_next     = mid_code;
    data_ok_next      = data_ok;
    child_idx_next    = child_idx;
    pend_valid_next   = pend_valid;
    pend_sym_next     = pend_sym;
    ram_re            = 1'b0;
    rd_idx            = walk_cur;
    bs_ctl            = '0;
    push              = 1'b0;
    push_data         = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_LOAD) begin
            data_ok_next = 1'b0;  // cached node may be stale
          end else begin
            bs_ctl.load = 1'b1;
            if (in_data.bit_count != '0) begin
              state_next = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        if (!data_ok) begin
          // fetch the node the walk stands on
          ram_re       = 1'b1;
          rd_idx       = walk_cur;
          data_ok_next = 1'b1;
        end else begin
          bs_ctl.shift = 1'b1;
          if (!step_has) begin
            // absent child: bit dropped, walk stays put
            current_node_next = walk_cur;
            mid_code_next     = 1'b1;
            if (bs_stat.one_left) begin
              state_next = S_FLUSH;
            end
          end else begin
            ram_re         = 1'b1;
            rd_idx         = step_child;
            child_idx_next = step_child;
            state_next     = S_CHILD;
          end
        end
      end

      S_CHILD: begin
        if (child_leaf) begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              push                   = 1'b1;
              push_data.symbol       = pend_sym;
              push_data.last_of_item = 1'b0;
            end
            pend_valid_next   = 1'b1;
            pend_sym_next     = node_rd.leaf_symbol;
            current_node_next = root_index;
            mid_code_next     = 1'b0;
            data_ok_next      = 1'b0;
            state_next        = bs_stat.empty ? S_FLUSH : S_WALK;
          end
        end else begin
          // RAM output now holds the new current node
          current_node_next = child_idx;
          mid_code_next     = 1'b1;
          data_ok_next      = 1'b1;
          state_next        = bs_stat.empty ? S_FLUSH : S_WALK;
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push                   = 1'b1;
          push_data.symbol       = pend_sym;
          push_data.last_of_item = 1'b1;
          pend_valid_next        = 1'b0;
          state_next             = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_index   <= '0;
      current_node <= '0;
      mid_code     <= 1'b0;
      data_ok      <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      current_node <= current_node_next;
      mid_code     <= mid_code_next;
      pend_valid   <= pend_valid_next;
      if (cfg_valid && cfg_ready) begin
        root_index <= cfg_data;
        data_ok    <= 1'b0;
      end else begin
        data_ok    <= data_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    child_idx <= child_idx_next;
    pend_sym  <= pend_sym_next;
  end

  // output register: a waiting result blocks the walk only when another symbol must be pushed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule
